@@ rtl/smem_pkg.sv @@
// Shared types and constants of the two-set membership engine.
// No dependencies; imported by smem_front, smem_back and the top level.
package smem_pkg;

  localparam int CAPACITY    = 16;
  localparam int VALUE_BITS  = 32;
  localparam int IN_BITS     = 32;
  localparam int MEMBER_BITS = 32;
  localparam int OP_BITS     = 3;
  localparam int STAT_BITS   = 2;
  localparam int COUNT_BITS  = 5;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // command queue depth, power of two so the pointers wrap on their own
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = QPTR_W + 1;

  localparam logic [OP_BITS-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_BITS-1:0] OP_DELETE = 3'd1;
  localparam logic [OP_BITS-1:0] OP_FIND   = 3'd2;
  localparam logic [OP_BITS-1:0] OP_CLEAR  = 3'd3;
  localparam logic [OP_BITS-1:0] OP_UNION  = 3'd4;
  localparam logic [OP_BITS-1:0] OP_INTER  = 3'd5;
  localparam logic [OP_BITS-1:0] OP_DIFF   = 3'd6;

  localparam logic [STAT_BITS-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_BITS-1:0] STAT_DUP  = 2'd1;
  localparam logic [STAT_BITS-1:0] STAT_FULL = 2'd2;
  localparam logic [STAT_BITS-1:0] STAT_MISS = 2'd3;

  typedef enum logic [2:0] {
    K_INSERT,
    K_DELETE,
    K_FIND,
    K_CLEAR,
    K_UNION,
    K_INTER,
    K_DIFF,
    K_NOP
  } kind_t;

  typedef struct packed {
    kind_t                         kind;
    logic                          combine;
    logic                          set;
    logic signed [VALUE_BITS-1:0]  key;
  } cmd_t;

endpackage

@@ rtl/two_set_membership_engine_top.sv @@
// Channel   Ports                                              Direction
// in        in_valid in_ready in_op in_which_set in_value      into block
// out       out_valid out_ready out_status out_count out_is_empty
//           out_member out_member_valid out_last               out of block
//
// Insert, delete, find, clear: one item per cycle sustained while out_ready
// stays high; the result word is registered when the command leaves the queue.
// Union walks both sets in two passes, intersection and difference one pass,
// one slot a cycle; a result stall holds the walk.
// The front queue holds QDEPTH words, so input is taken during a walk until full.
// Synchronous active-low reset empties both sets and the queue at once.
// Top level of the two-set membership engine: front queue and back executor.
// Depends on smem_pkg, smem_front and smem_back.
module two_set_membership_engine_top import smem_pkg::*; (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [OP_BITS-1:0]             in_op,
  input  logic                           in_which_set,
  input  logic signed [IN_BITS-1:0]      in_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [STAT_BITS-1:0]           out_status,
  output logic [COUNT_BITS-1:0]          out_count,
  output logic                           out_is_empty,
  output logic signed [MEMBER_BITS-1:0]  out_member,
  output logic                           out_member_valid,
  output logic                           out_last
);

  cmd_t q_cmd;
  logic q_valid;
  logic q_pop;

  smem_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_which_set (in_which_set),
    .in_value     (in_value),
    .q_cmd        (q_cmd),
    .q_valid      (q_valid),
    .q_pop        (q_pop)
  );

  smem_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_cmd            (q_cmd),
    .q_valid          (q_valid),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_count        (out_count),
    .out_is_empty     (out_is_empty),
    .out_member       (out_member),
    .out_member_valid (out_member_valid),
    .out_last         (out_last)
  );

endmodule

@@ rtl/smem_front.sv @@
// Front end: accepts input words, classifies the operation and queues commands.
// Depends on smem_pkg.
module smem_front import smem_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [OP_BITS-1:0]         in_op,
  input  logic                       in_which_set,
  input  logic signed [IN_BITS-1:0]  in_value,
  output cmd_t                       q_cmd,
  output logic                       q_valid,
  input  logic                       q_pop
);

  cmd_t              q_mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] q_cnt_r, q_cnt_nxt;
  cmd_t              cmd_in;
  logic              push;

  always_comb begin
    cmd_in.set     = in_which_set;
    cmd_in.key     = VALUE_BITS'(in_value);
    cmd_in.combine = 1'b0;
    unique case (in_op)
      OP_INSERT: cmd_in.kind = K_INSERT;
      OP_DELETE: cmd_in.kind = K_DELETE;
      OP_FIND:   cmd_in.kind = K_FIND;
      OP_CLEAR:  cmd_in.kind = K_CLEAR;
      OP_UNION: begin
        cmd_in.kind    = K_UNION;
        cmd_in.combine = 1'b1;
      end
      OP_INTER: begin
        cmd_in.kind    = K_INTER;
        cmd_in.combine = 1'b1;
      end
      OP_DIFF: begin
        cmd_in.kind    = K_DIFF;
        cmd_in.combine = 1'b1;
      end
      default:   cmd_in.kind = K_NOP;
    endcase
  end

  assign in_ready = (q_cnt_r != QCNT_W'(QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (q_cnt_r != '0);
  assign q_cmd    = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? QPTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? QPTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    q_cnt_nxt  = q_cnt_r;
    if (push && !q_pop) begin
      q_cnt_nxt = QCNT_W'(q_cnt_r + 1'b1);
    end else if (!push && q_pop) begin
      q_cnt_nxt = QCNT_W'(q_cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      q_cnt_r  <= q_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

@@ rtl/smem_back.sv @@
// Back end: holds both sets, executes queued commands, walks combining runs
// and drives the registered result channel. Depends on smem_pkg.
module smem_back import smem_pkg::*; (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cmd_t                           q_cmd,
  input  logic                           q_valid,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [STAT_BITS-1:0]           out_status,
  output logic [COUNT_BITS-1:0]          out_count,
  output logic                           out_is_empty,
  output logic signed [MEMBER_BITS-1:0]  out_member,
  output logic                           out_member_valid,
  output logic                           out_last
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t                        state_r, state_nxt;
  logic signed [VALUE_BITS-1:0]  val_r [2][CAPACITY];
  logic [CAPACITY-1:0]           vld_r [2];
  logic [CAPACITY-1:0]           vld_nxt [2];
  logic [CNT_W-1:0]              cnt_r [2];
  logic [CNT_W-1:0]              cnt_nxt [2];

  kind_t                         kind_r, kind_nxt;
  logic                          set_r, set_nxt;
  logic                          pass_r, pass_nxt;
  logic [IDX_W-1:0]              idx_r, idx_nxt;
  logic signed [VALUE_BITS-1:0]  pend_r, pend_nxt;
  logic                          pend_v_r, pend_v_nxt;

  logic                          out_valid_r;
  logic [STAT_BITS-1:0]          out_status_r;
  logic [COUNT_BITS-1:0]         out_count_r;
  logic                          out_empty_r;
  logic signed [MEMBER_BITS-1:0] out_member_r;
  logic                          out_mvalid_r;
  logic                          out_last_r;

  logic                          out_free, out_load;
  logic [STAT_BITS-1:0]          o_status;
  logic [CNT_W-1:0]              o_cnt;
  logic signed [MEMBER_BITS-1:0] o_member;
  logic                          o_mvalid, o_last;

  // single operation on the addressed set
  logic                          sa;
  logic [CAPACITY-1:0]           hitv, freev, s_vld, s_wr, wr_v;
  logic                          hit;
  logic [STAT_BITS-1:0]          s_status;
  logic [CNT_W-1:0]              s_cnt;

  // combining walk
  logic                          src, chk;
  logic signed [VALUE_BITS-1:0]  cand;
  logic                          cand_ok, chit, emit, last_idx;
  logic [CAPACITY-1:0]           chitv;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    sa = q_cmd.set;
    for (int j = 0; j < CAPACITY; j++) begin
      hitv[j] = vld_r[sa][j] && (val_r[sa][j] == q_cmd.key);
    end
    hit      = |hitv;
    freev    = ~vld_r[sa] & (vld_r[sa] + CAPACITY'(1));
    s_vld    = vld_r[sa];
    s_cnt    = cnt_r[sa];
    s_wr     = '0;
    s_status = STAT_OK;
    unique case (q_cmd.kind)
      K_INSERT: begin
        if (hit) begin
          s_status = STAT_DUP;
        end else if (freev == '0) begin
          s_status = STAT_FULL;
        end else begin
          s_wr  = freev;
          s_vld = vld_r[sa] | freev;
          s_cnt = CNT_W'(cnt_r[sa] + 1'b1);
        end
      end
      K_DELETE: begin
        if (hit) begin
          s_vld = vld_r[sa] & ~hitv;
          s_cnt = CNT_W'(cnt_r[sa] - 1'b1);
        end else begin
          s_status = STAT_MISS;
        end
      end
      K_FIND: begin
        if (!hit) begin
          s_status = STAT_MISS;
        end
      end
      K_CLEAR: begin
        s_vld = '0;
        s_cnt = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    src      = set_r ^ pass_r;
    chk      = ~src;
    cand     = val_r[src][idx_r];
    cand_ok  = vld_r[src][idx_r];
    for (int j = 0; j < CAPACITY; j++) begin
      chitv[j] = vld_r[chk][j] && (val_r[chk][j] == cand);
    end
    chit     = |chitv;
    last_idx = (idx_r == IDX_W'(CAPACITY - 1));
    if (pass_r) begin
      emit = cand_ok && !chit;
    end else begin
      unique case (kind_r)
        K_UNION: emit = cand_ok;
        K_INTER: emit = cand_ok && chit;
        K_DIFF:  emit = cand_ok && !chit;
        default: emit = 1'b0;
      endcase
    end
  end

  always_comb begin
    state_nxt  = state_r;
    kind_nxt   = kind_r;
    set_nxt    = set_r;
    pass_nxt   = pass_r;
    idx_nxt    = idx_r;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    vld_nxt    = vld_r;
    cnt_nxt    = cnt_r;
    wr_v       = '0;
    q_pop      = 1'b0;
    out_load   = 1'b0;
    o_status   = STAT_OK;
    o_cnt      = cnt_r[set_r];
    o_member   = '0;
    o_mvalid   = 1'b0;
    o_last     = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          if (q_cmd.combine) begin
            q_pop      = 1'b1;
            kind_nxt   = q_cmd.kind;
            set_nxt    = q_cmd.set;
            pass_nxt   = 1'b0;
            idx_nxt    = '0;
            pend_v_nxt = 1'b0;
            state_nxt  = S_WALK;
          end else if (out_free) begin
            q_pop       = 1'b1;
            out_load    = 1'b1;
            o_status    = s_status;
            o_cnt       = s_cnt;
            vld_nxt[sa] = s_vld;
            cnt_nxt[sa] = s_cnt;
            wr_v        = s_wr;
          end
        end
      end
      S_WALK: begin
        if (!(emit && pend_v_r && !out_free)) begin
          if (emit) begin
            if (pend_v_r) begin
              out_load = 1'b1;
              o_member = MEMBER_BITS'(pend_r);
              o_mvalid = 1'b1;
              o_last   = 1'b0;
            end
            pend_nxt   = cand;
            pend_v_nxt = 1'b1;
          end
          if (last_idx) begin
            idx_nxt = '0;
            if (!pass_r && kind_r == K_UNION) begin
              pass_nxt = 1'b1;
            end else begin
              state_nxt = S_DONE;
            end
          end else begin
            idx_nxt = IDX_W'(idx_r + 1'b1);
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          o_member  = pend_v_r ? MEMBER_BITS'(pend_r) : '0;
          o_mvalid  = pend_v_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vld_r       <= '{default: '0};
      cnt_r       <= '{default: '0};
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      vld_r    <= vld_nxt;
      cnt_r    <= cnt_nxt;
      pend_v_r <= pend_v_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    set_r  <= set_nxt;
    pass_r <= pass_nxt;
    idx_r  <= idx_nxt;
    pend_r <= pend_nxt;
    for (int j = 0; j < CAPACITY; j++) begin
      if (wr_v[j]) begin
        val_r[sa][j] <= q_cmd.key;
      end
    end
    if (out_load) begin
      out_status_r <= o_status;
      out_count_r  <= COUNT_BITS'(o_cnt);
      out_empty_r  <= (o_cnt == '0);
      out_member_r <= o_member;
      out_mvalid_r <= o_mvalid;
      out_last_r   <= o_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_count        = out_count_r;
  assign out_is_empty     = out_empty_r;
  assign out_member       = out_member_r;
  assign out_member_valid = out_mvalid_r;
  assign out_last         = out_last_r;

`ifndef ASSERT_OFF
  a_cnt0: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[0] == CNT_W'($countones(vld_r[0])))
    else $error("set 0 count out of step with valid marks");
  a_cnt1: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[1] == CNT_W'($countones(vld_r[1])))
    else $error("set 1 count out of step with valid marks");
  a_nopop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !q_pop)
    else $error("queue popped during a walk");
  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_load) |=> (out_valid_r && out_last_r))
    else $error("combining run not closed with last");
`endif

endmodule
